### hdl/cst_pkg.sv
// Shared types and constants of the checkpoint slot table.
package cst_pkg;
	localparam int SLOTS = 16;
	localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int OWNER_W = 32;

	typedef logic [63:0] word_t;
	typedef logic [2:0] code_t;
	typedef logic [1:0] sstate_t;

	localparam code_t CMD_PREPARE = 3'd0;
	localparam code_t CMD_COMMIT = 3'd1;
	localparam code_t CMD_INVAL = 3'd2;
	localparam code_t CMD_LATEST = 3'd3;
	localparam code_t CMD_GET = 3'd4;

	localparam code_t STS_OK = 3'd0;
	localparam code_t STS_INVAL = 3'd1;
	localparam code_t STS_NOSPACE = 3'd2;
	localparam code_t STS_STATE = 3'd3;
	localparam code_t STS_NOENT = 3'd4;

	localparam sstate_t ST_EMPTY = 2'd0;
	localparam sstate_t ST_PREPARED = 2'd1;
	localparam sstate_t ST_COMMITTED = 2'd2;
	localparam sstate_t ST_INVALID = 2'd3;

	localparam word_t MIX_K1 = 64'hbf58476d1ce4e5b9;
	localparam word_t MIX_K2 = 64'h94d049bb133111eb;
	localparam word_t TAG_SEED = 64'h4e45584f52415031;

	typedef struct packed {
		word_t id;
		logic [OWNER_W-1:0] owner;
		word_t gen;
		word_t pay;
		word_t created;
		word_t tag;
	} rec_t;

	localparam int REC_W = $bits(rec_t);
endpackage

### hdl/cst_in_if.sv
// Command channel of the checkpoint slot table.
interface cst_in_if;
	logic valid;
	logic ready;
	cst_pkg::code_t command;
	logic [cst_pkg::OWNER_W-1:0] owner;
	cst_pkg::word_t generation_in;
	cst_pkg::word_t payload_in;
	cst_pkg::word_t now_time;
	cst_pkg::word_t target_id;
	modport source(output valid, command, owner, generation_in, payload_in, now_time,
		target_id, input ready);
	modport sink(input valid, command, owner, generation_in, payload_in, now_time,
		target_id, output ready);
endinterface

### hdl/cst_out_if.sv
// Result channel of the checkpoint slot table.
interface cst_out_if;
	logic valid;
	logic ready;
	cst_pkg::code_t status;
	logic found;
	cst_pkg::word_t result_id;
	logic [cst_pkg::OWNER_W-1:0] result_owner;
	cst_pkg::word_t result_generation;
	cst_pkg::word_t result_payload;
	cst_pkg::word_t result_created;
	cst_pkg::word_t result_tag;
	modport source(output valid, status, found, result_id, result_owner, result_generation,
		result_payload, result_created, result_tag, input ready);
	modport sink(input valid, status, found, result_id, result_owner, result_generation,
		result_payload, result_created, result_tag, output ready);
endinterface

### hdl/cst_ram.sv
// Generic single-write, single-read RAM with registered read data.
module cst_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input logic clk,
	input logic we,
	input logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

### hdl/cst_hash.sv
// Integrity tag unit: five field mixes and a final mix on one 32x32 multiplier.
module cst_hash (
	input logic clk,
	input logic arst_n,
	input logic start,
	input cst_pkg::rec_t fields,
	output logic done,
	output cst_pkg::word_t tag
);
	import cst_pkg::*;

	typedef enum logic [5:0] {
		H_IDLE = 6'b000001,
		H_PRE = 6'b000010,
		H_MUL1 = 6'b000100,
		H_MID = 6'b001000,
		H_MUL2 = 6'b010000,
		H_POST = 6'b100000
	} hstate_t;

	hstate_t hs_q;
	logic [2:0] term_q;
	logic [1:0] m_q;
	word_t x_q, h_q, acc_q, prod_q, tag_q;
	logic done_q;
	word_t src, kmul, mixed;
	logic [31:0] a_op, b_op;

	always_comb begin
		case (term_q)
			3'd0: src = fields.id;
			3'd1: src = {31'd0, fields.owner, 1'b0};
			3'd2: src = fields.gen << 7;
			3'd3: src = fields.pay << 13;
			3'd4: src = fields.created << 19;
			default: src = h_q;
		endcase
		kmul = (hs_q == H_MUL1) ? MIX_K1 : MIX_K2;
		a_op = (m_q == 2'd2) ? x_q[63:32] : x_q[31:0];
		b_op = (m_q == 2'd1) ? kmul[63:32] : kmul[31:0];
		mixed = acc_q ^ (acc_q >> 31);
	end

	always_ff @(posedge clk) begin
		prod_q <= 64'(a_op) * 64'(b_op);
		if (hs_q == H_MUL1 || hs_q == H_MUL2) begin
			if (m_q == 2'd1) begin
				acc_q <= prod_q;
			end else if (m_q != 2'd0) begin
				acc_q <= acc_q + {prod_q[31:0], 32'd0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hs_q <= H_IDLE;
			term_q <= '0;
			m_q <= '0;
			done_q <= 1'b0;
			x_q <= '0;
			h_q <= '0;
			tag_q <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (hs_q)
				H_IDLE: begin
					if (start) begin
						h_q <= TAG_SEED;
						term_q <= '0;
						hs_q <= H_PRE;
					end
				end
				H_PRE: begin
					x_q <= src ^ (src >> 30);
					m_q <= '0;
					hs_q <= H_MUL1;
				end
				H_MUL1: begin
					m_q <= m_q + 2'd1;
					if (m_q == 2'd3) begin
						hs_q <= H_MID;
					end
				end
				H_MID: begin
					x_q <= acc_q ^ (acc_q >> 27);
					m_q <= '0;
					hs_q <= H_MUL2;
				end
				H_MUL2: begin
					m_q <= m_q + 2'd1;
					if (m_q == 2'd3) begin
						hs_q <= H_POST;
					end
				end
				H_POST: begin
					if (term_q == 3'd5) begin
						tag_q <= mixed;
						done_q <= 1'b1;
						hs_q <= H_IDLE;
					end else begin
						h_q <= h_q ^ mixed;
						term_q <= term_q + 3'd1;
						hs_q <= H_PRE;
					end
				end
				default: hs_q <= H_IDLE;
			endcase
		end
	end

	assign done = done_q;
	assign tag = tag_q;
endmodule

### hdl/checkpoint_slot_table.sv
// Checkpoint slot table: slot scan over a RAM plus a tag hash unit used by prepare.
// Each command scans every slot and then registers its result; prepare also waits for the tag hash.
// The table takes no new command until the result of the last one has been taken.
// The hash unit does three 32x32 partial products per 64-bit multiply,
// twelve multiplies. Reset clears all slot states to empty and the id counter to one at once;
// slot records of empty slots are never looked at, so no clearing pass is needed.
module checkpoint_slot_table (
	input logic clk,
	input logic arst_n,
	cst_in_if.sink req,
	cst_out_if.source rsp
);
	import cst_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_SCAN = 5'b00010,
		S_FIN = 5'b00100,
		S_HASH = 5'b01000,
		S_DONE = 5'b10000
	} state_t;

	state_t state_q;
	sstate_t st_q [SLOTS];
	word_t nid_q, id_q;
	code_t cmd_q;
	logic [OWNER_W-1:0] own_q;
	word_t gen_q, pay_q, now_q, tid_q;
	logic [SLOT_W:0] idx_q;
	logic rv_s1;
	logic [SLOT_W-1:0] ri_s1, sel_q, free_idx_q, slot_q;
	logic have_q, free_have_q;
	rec_t best_q, rd, hfields;
	logic take, free_have, hstart, hdone, we;
	logic [SLOT_W-1:0] free_idx;
	sstate_t ent_st;
	word_t htag, id_new;
	rec_t wrec;

	code_t out_sts_q;
	logic out_found_q, out_v_q;
	word_t out_id_q;
	rec_t out_rec_q;

	cst_ram #(.WIDTH(REC_W), .DEPTH(SLOTS)) u_ram (
		.clk(clk), .we(we), .waddr(slot_q), .wdata(wrec),
		.raddr(idx_q[SLOT_W-1:0]), .rdata(rd)
	);

	assign hfields = '{id: id_q, owner: own_q, gen: gen_q, pay: pay_q, created: now_q,
		tag: '0};

	cst_hash u_hash (
		.clk(clk), .arst_n(arst_n), .start(hstart), .fields(hfields),
		.done(hdone), .tag(htag)
	);

	assign we = hdone;
	assign wrec = '{id: id_q, owner: own_q, gen: gen_q, pay: pay_q, created: now_q,
		tag: htag};
	assign id_new = (nid_q == '0) ? 64'd1 : nid_q;

	always_comb begin
		free_have = 1'b0;
		free_idx = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (st_q[i] == ST_EMPTY || st_q[i] == ST_INVALID) begin
				free_have = 1'b1;
				free_idx = SLOT_W'(i);
			end
		end
	end

	always_comb begin
		ent_st = st_q[ri_s1];
		case (cmd_q) inside
			CMD_PREPARE: take = ent_st == ST_COMMITTED &&
				(!have_q || rd.created < best_q.created);
			CMD_COMMIT, CMD_INVAL: take = !have_q && tid_q != '0 && ent_st != ST_EMPTY &&
				rd.id == tid_q;
			CMD_LATEST: take = ent_st == ST_COMMITTED && rd.owner == own_q &&
				(!have_q || rd.gen > best_q.gen ||
				(rd.gen == best_q.gen && rd.created > best_q.created));
			CMD_GET: take = !have_q && ent_st == ST_COMMITTED && rd.id == tid_q &&
				rd.owner == own_q;
			default: take = 1'b0;
		endcase
	end

	assign hstart = (state_q == S_FIN) && cmd_q == CMD_PREPARE && own_q != '0 &&
		(free_have_q || have_q);

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && req.valid) begin
			cmd_q <= req.command;
			own_q <= req.owner;
			gen_q <= req.generation_in;
			pay_q <= req.payload_in;
			now_q <= req.now_time;
			tid_q <= req.target_id;
			free_have_q <= free_have;
			free_idx_q <= free_idx;
		end
		if (rv_s1 && take) begin
			best_q <= rd;
			sel_q <= ri_s1;
		end
		ri_s1 <= idx_q[SLOT_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			for (int i = 0; i < SLOTS; i++) begin
				st_q[i] <= ST_EMPTY;
			end
			nid_q <= 64'd1;
			idx_q <= '0;
			rv_s1 <= 1'b0;
			have_q <= 1'b0;
			out_v_q <= 1'b0;
			out_sts_q <= STS_OK;
			out_found_q <= 1'b0;
			out_id_q <= '0;
			out_rec_q <= '0;
			id_q <= '0;
			slot_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					rv_s1 <= 1'b0;
					if (req.valid) begin
						idx_q <= '0;
						have_q <= 1'b0;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (idx_q < (SLOT_W + 1)'(SLOTS)) begin
						idx_q <= idx_q + (SLOT_W + 1)'(1);
						rv_s1 <= 1'b1;
					end else begin
						rv_s1 <= 1'b0;
					end
					if (rv_s1 && take) begin
						have_q <= 1'b1;
					end
					if (rv_s1 && ri_s1 == SLOT_W'(SLOTS - 1)) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					rv_s1 <= 1'b0;
					out_sts_q <= STS_OK;
					out_found_q <= 1'b0;
					out_id_q <= '0;
					out_rec_q <= '0;
					state_q <= S_DONE;
					case (cmd_q) inside
						CMD_PREPARE: begin
							if (own_q == '0) begin
								out_sts_q <= STS_INVAL;
							end else if (!(free_have_q || have_q)) begin
								out_sts_q <= STS_NOSPACE;
							end else begin
								id_q <= id_new;
								nid_q <= id_new + 64'd1;
								slot_q <= free_have_q ? free_idx_q : sel_q;
								st_q[free_have_q ? free_idx_q : sel_q] <= ST_PREPARED;
								out_id_q <= id_new;
								state_q <= S_HASH;
							end
						end
						CMD_COMMIT: begin
							if (!have_q) begin
								out_sts_q <= STS_NOENT;
							end else if (st_q[sel_q] != ST_PREPARED) begin
								out_sts_q <= STS_STATE;
							end else begin
								st_q[sel_q] <= ST_COMMITTED;
							end
						end
						CMD_INVAL: begin
							if (!have_q) begin
								out_sts_q <= STS_NOENT;
							end else begin
								st_q[sel_q] <= ST_INVALID;
							end
						end
						CMD_LATEST, CMD_GET: begin
							if (own_q == '0) begin
								out_sts_q <= STS_INVAL;
							end else if (!have_q) begin
								out_sts_q <= STS_NOENT;
							end else begin
								out_found_q <= 1'b1;
								out_id_q <= best_q.id;
								out_rec_q <= best_q;
							end
						end
						default: out_sts_q <= STS_INVAL;
					endcase
				end
				S_HASH: begin
					if (hdone) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (rsp.ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
			out_v_q <= (state_q == S_FIN && !hstart) || (state_q == S_HASH && hdone) ||
				(state_q == S_DONE && !rsp.ready);
		end
	end

	assign req.ready = (state_q == S_IDLE);
	assign rsp.valid = out_v_q;
	assign rsp.status = out_sts_q;
	assign rsp.found = out_found_q;
	assign rsp.result_id = out_id_q;
	assign rsp.result_owner = out_rec_q.owner;
	assign rsp.result_generation = out_rec_q.gen;
	assign rsp.result_payload = out_rec_q.pay;
	assign rsp.result_created = out_rec_q.created;
	assign rsp.result_tag = out_rec_q.tag;

	a_out_blocks_in: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> !req.ready) else $error("item taken while result pending");
	a_hash_start: assert property (@(posedge clk) disable iff (!arst_n)
		hstart |=> state_q == S_HASH) else $error("hash started outside prepare");
	a_hash_done: assert property (@(posedge clk) disable iff (!arst_n)
		hdone |-> state_q == S_HASH) else $error("stray hash completion");
	a_scan_valid: assert property (@(posedge clk) disable iff (!arst_n)
		rv_s1 |-> state_q == S_SCAN) else $error("slot read outside scan");
endmodule
